[rtl/mfl_pkg.sv]
// Shared types, constants and lookup functions for the mbox From_ line recognizer.
// No dependencies.
package mfl_pkg;

    localparam int FROM_LEN = 5;

    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       end_of_line;
    } byte_beat_t;

    typedef struct packed
    {
        logic is_header;
        logic saw_tty;
    } verdict_beat_t;

    typedef struct packed
    {
        logic zero;
        logic blank;
        logic space;
        logic digit;
        logic lower;
        logic alpha;
        logic colon;
        logic quote;
    } char_class_t;

    typedef enum logic [2:0]
    {
        CL_A,
        CL_L,
        CL_S,
        CL_O,
        CL_D,
        CL_C,
        CL_B
    } tmpl_class_t;

    function automatic tmpl_class_t date_class(input logic [4:0] p);
        tmpl_class_t cls;
        unique case (p)
            5'd0, 5'd4:                          cls = CL_A;
            5'd1, 5'd2, 5'd5, 5'd6:              cls = CL_L;
            5'd3, 5'd7, 5'd10, 5'd19:            cls = CL_S;
            5'd8:                                cls = CL_O;
            5'd9, 5'd11, 5'd12, 5'd14, 5'd15,
            5'd17, 5'd18:                        cls = CL_D;
            5'd13, 5'd16:                        cls = CL_C;
            default:                             cls = CL_B;
        endcase
        return cls;
    endfunction

    function automatic logic [7:0] from_char(input logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0:    ch = 8'h46;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h6F;
            3'd3:    ch = 8'h6D;
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] tty_char(input logic [1:0] i);
        logic [7:0] ch;
        unique case (i)
            2'd2:    ch = 8'h79;
            default: ch = 8'h74;
        endcase
        return ch;
    endfunction

endpackage

[rtl/mfl_char_class.sv]
// Character classifier: flags each byte as blank, space, digit, letter, colon, quote, zero.
// Depends on mfl_pkg.
module mfl_char_class
    import mfl_pkg::*;
(
    input  logic [7:0]  data_byte,
    output char_class_t cls
);

    always_comb
    begin
        cls.zero  = (data_byte == 8'h00);
        cls.blank = (data_byte == 8'h20) || (data_byte == 8'h09);
        cls.space = (data_byte == 8'h20) || ((data_byte >= 8'h09) && (data_byte <= 8'h0D));
        cls.digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
        cls.lower = (data_byte >= 8'h61) && (data_byte <= 8'h7A);
        cls.alpha = cls.lower || ((data_byte >= 8'h41) && (data_byte <= 8'h5A));
        cls.colon = (data_byte == 8'h3A);
        cls.quote = (data_byte == 8'h22);
    end

endmodule

[rtl/mfl_line_fsm.sv]
// Per-line recognizer state machine: prefix, sender word, tty word, date template.
// Depends on mfl_pkg and mfl_char_class.
module mfl_line_fsm
    import mfl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  byte_beat_t    beat,
    output verdict_beat_t verdict
);

    typedef enum logic [3:0]
    {
        PH_PREFIX,
        PH_SKIP1,
        PH_SENDER,
        PH_SKIP2,
        PH_DATE,
        PH_TTYWORD,
        PH_SKIP3,
        PH_ACCEPT,
        PH_REJECT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  position_reg, position_next;
    logic        inside_quote_reg, inside_quote_next;
    logic        tty_prefix_reg, tty_prefix_next;
    logic        tty_found_reg, tty_found_next;

    char_class_t cls;
    logic [7:0]  c;
    logic [4:0]  p;
    tmpl_class_t tcls;
    logic        checking;
    logic        tty_ok;
    logic        cls_ok;

    assign c = beat.data_byte;

    mfl_char_class u_class
    (
        .data_byte (c),
        .cls       (cls)
    );

    always_comb
    begin
        p        = (phase_reg == PH_DATE) ? position_reg : 5'd0;
        tcls     = date_class(p);
        checking = !tty_found_reg && tty_prefix_reg && (p < 5'd3);
        tty_ok   = (c == tty_char(p[1:0]));
        unique case (tcls)
            CL_A:    cls_ok = cls.alpha;
            CL_L:    cls_ok = cls.lower;
            CL_S:    cls_ok = cls.space;
            CL_O:    cls_ok = cls.space || cls.digit;
            CL_D:    cls_ok = cls.digit;
            CL_C:    cls_ok = cls.colon;
            default: cls_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        position_next     = position_reg;
        inside_quote_next = inside_quote_reg;
        tty_prefix_next   = tty_prefix_reg;
        tty_found_next    = tty_found_reg;

        if ((phase_reg == PH_ACCEPT) || (phase_reg == PH_REJECT))
        begin
            phase_next = phase_reg;
        end
        else if (cls.zero)
        begin
            phase_next = PH_REJECT;
        end
        else
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    if ((position_reg >= 5'(FROM_LEN)) || (c != from_char(position_reg[2:0])))
                        phase_next = PH_REJECT;
                    else if (position_reg == 5'(FROM_LEN - 1))
                    begin
                        position_next = 5'd0;
                        phase_next    = PH_SKIP1;
                    end
                    else
                        position_next = position_reg + 5'd1;
                end
                PH_SKIP1:
                begin
                    if (!cls.blank)
                    begin
                        phase_next        = PH_SENDER;
                        inside_quote_next = cls.quote;
                    end
                end
                PH_SENDER, PH_TTYWORD:
                begin
                    if (inside_quote_reg)
                    begin
                        if (cls.quote)
                            inside_quote_next = 1'b0;
                    end
                    else if (cls.blank)
                        phase_next = (phase_reg == PH_SENDER) ? PH_SKIP2 : PH_SKIP3;
                    else if (cls.quote)
                        inside_quote_next = 1'b1;
                end
                PH_SKIP2, PH_SKIP3, PH_DATE:
                begin
                    if ((phase_reg == PH_DATE) || !cls.blank)
                    begin
                        phase_next    = PH_DATE;
                        position_next = p;
                        if (checking && !tty_ok)
                            tty_prefix_next = 1'b0;
                        if (tcls == CL_B)
                            phase_next = PH_ACCEPT;
                        else if (!cls_ok)
                            phase_next = PH_REJECT;
                        else if (checking && tty_ok && (p == 5'd2))
                        begin
                            tty_found_next    = 1'b1;
                            inside_quote_next = 1'b0;
                            position_next     = 5'd0;
                            phase_next        = PH_TTYWORD;
                        end
                        else
                            position_next = p + 5'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_REJECT;
                end
            endcase
        end
    end

    assign verdict.is_header = (phase_next == PH_ACCEPT);
    assign verdict.saw_tty   = tty_found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PREFIX;
            position_reg     <= 5'd0;
            inside_quote_reg <= 1'b0;
            tty_prefix_reg   <= 1'b1;
            tty_found_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            if (beat.end_of_line)
            begin
                phase_reg        <= PH_PREFIX;
                position_reg     <= 5'd0;
                inside_quote_reg <= 1'b0;
                tty_prefix_reg   <= 1'b1;
                tty_found_reg    <= 1'b0;
            end
            else
            begin
                phase_reg        <= phase_next;
                position_reg     <= position_next;
                inside_quote_reg <= inside_quote_next;
                tty_prefix_reg   <= tty_prefix_next;
                tty_found_reg    <= tty_found_next;
            end
        end
    end

endmodule

[rtl/mbox_from_line_recognizer.sv]
// Top level of the mbox From_ line recognizer: input register, line state machine,
// verdict register. Depends on mfl_pkg and mfl_line_fsm.
//
//   channel   direction  handshake                     beat
//   byte      in         byte_valid / byte_ready       byte_beat_t    (one character)
//   verdict   out        verdict_valid / verdict_ready verdict_beat_t (one per line)
//
// One byte per cycle sustained unless a last byte waits on a full verdict register; the line's
// last byte is taken into the input register, then its verdict into the verdict register.
// Reset clears both valid flags and returns the line state to the prefix check.
// A byte that is not last in its line never waits on the output; a last byte waits in
// the input register only while the verdict register is full and not being taken.
module mbox_from_line_recognizer
    import mfl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  byte_beat_t    byte_beat,
    output logic          verdict_valid,
    input  logic          verdict_ready,
    output verdict_beat_t verdict_beat
);

    byte_beat_t    in_beat_reg;
    logic          in_valid_reg;
    verdict_beat_t out_beat_reg;
    logic          out_valid_reg;
    verdict_beat_t verdict;
    logic          out_free;
    logic          advance;

    assign out_free   = !out_valid_reg || verdict_ready;
    assign advance    = in_valid_reg && (!in_beat_reg.end_of_line || out_free);
    assign byte_ready = !in_valid_reg || advance;

    mfl_line_fsm u_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .beat    (in_beat_reg),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ready)
                in_valid_reg <= byte_valid;
            if (advance && in_beat_reg.end_of_line)
                out_valid_reg <= 1'b1;
            else if (verdict_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            in_beat_reg <= byte_beat;
        if (advance && in_beat_reg.end_of_line)
            out_beat_reg <= verdict;
    end

    assign verdict_valid = out_valid_reg;
    assign verdict_beat  = out_beat_reg;

endmodule

[tb/sv/mbox_from_line_recognizer_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for mbox_from_line_recognizer: line generator, byte driver,
// verdict monitor and a cycle-free predictor of the From_ line verdict.
// Depends on mfl_pkg and the recognizer RTL.
module mbox_from_line_recognizer_test;
    import mfl_pkg::*;

    typedef enum logic [3:0]
    {
        ST_PREFIX,
        ST_SKIP1,
        ST_SENDER,
        ST_SKIP2,
        ST_DATE,
        ST_TTYWORD,
        ST_SKIP3,
        ST_ACCEPT,
        ST_REJECT
    } line_phase_t;

    localparam int          IDLE_LIMIT = 2000;
    localparam logic [39:0] FROM_TEXT  = "From ";
    localparam logic [23:0] TTY_TEXT   = "tty";

    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          byte_valid    = 1'b0;
    logic          byte_ready;
    byte_beat_t    byte_beat     = '0;
    logic          verdict_valid;
    logic          verdict_ready = 1'b0;
    verdict_beat_t verdict_beat;

    tmpl_class_t ctime_tmpl [21] = '{CL_A, CL_L, CL_L, CL_S, CL_A, CL_L, CL_L, CL_S, CL_O,
                                     CL_D, CL_S, CL_D, CL_D, CL_C, CL_D, CL_D, CL_C, CL_D,
                                     CL_D, CL_S, CL_B};

    // predictor state
    line_phase_t ln_phase    = ST_PREFIX;
    logic [4:0]  ln_pos      = '0;
    bit          ln_quote    = 1'b0;
    bit          ln_tty_run  = 1'b1;
    bit          ln_tty_seen = 1'b0;

    logic [7:0]    line_buf [$];
    byte_beat_t    byte_items [$];
    verdict_beat_t verdicts_due [$];
    int            line_count;
    int            mismatches;
    int            idle_cycles;

    int send_gap;
    bit send_quiet;
    int send_run;
    int stall_gap;
    bit stall_quiet;
    int stall_run;

    mbox_from_line_recognizer i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_beat     (byte_beat),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_beat  (verdict_beat)
    );

    always #1 clk = ~clk;

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || c == 8'h09;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_lower(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic bit fits_class(tmpl_class_t cls, logic [7:0] c);
        case (cls)
            CL_L:    return is_lower(c);
            CL_S:    return is_space(c);
            CL_D:    return is_digit(c);
            CL_O:    return is_space(c) || is_digit(c);
            CL_C:    return c == ":";
            CL_A:    return is_lower(c) || (c >= "A" && c <= "Z");
            default: return 1'b1;
        endcase
    endfunction

    function automatic void clear_line_state();
        ln_phase    = ST_PREFIX;
        ln_pos      = '0;
        ln_quote    = 1'b0;
        ln_tty_run  = 1'b1;
        ln_tty_seen = 1'b0;
    endfunction

    // returns 1 when a blank outside quotes ends the word
    function automatic bit word_done(logic [7:0] c);
        if (ln_quote)
        begin
            if (c == "\"")
                ln_quote = 1'b0;
            return 1'b0;
        end
        if (is_blank(c))
            return 1'b1;
        if (c == "\"")
            ln_quote = 1'b1;
        return 1'b0;
    endfunction

    function automatic void date_char(logic [7:0] c);
        int p;
        bit tty_check;
        p = int'(ln_pos);
        tty_check = !ln_tty_seen && ln_tty_run && p < 3;
        if (tty_check && c != TTY_TEXT[23 - 8 * p -: 8])
            ln_tty_run = 1'b0;
        if (ctime_tmpl[p] == CL_B)
        begin
            ln_phase = ST_ACCEPT;
            return;
        end
        if (!fits_class(ctime_tmpl[p], c))
        begin
            ln_phase = ST_REJECT;
            return;
        end
        ln_pos = 5'(p + 1);
        if (tty_check && ln_tty_run && ln_pos == 5'd3)
        begin
            ln_tty_seen = 1'b1;
            ln_quote    = 1'b0;
            ln_pos      = '0;
            ln_phase    = ST_TTYWORD;
        end
    endfunction

    function automatic void take_char(logic [7:0] c);
        if (ln_phase == ST_ACCEPT || ln_phase == ST_REJECT)
            return;
        if (c == 8'h00)
        begin
            ln_phase = ST_REJECT;
            return;
        end
        case (ln_phase)
            ST_PREFIX:
            begin
                if (ln_pos >= FROM_LEN || c != FROM_TEXT[39 - 8 * int'(ln_pos) -: 8])
                    ln_phase = ST_REJECT;
                else
                begin
                    ln_pos = ln_pos + 5'd1;
                    if (ln_pos == FROM_LEN)
                    begin
                        ln_pos   = '0;
                        ln_phase = ST_SKIP1;
                    end
                end
            end
            ST_SKIP1, ST_SKIP2, ST_SKIP3:
            begin
                if (!is_blank(c))
                begin
                    if (ln_phase == ST_SKIP1)
                    begin
                        ln_phase = ST_SENDER;
                        ln_quote = 1'b0;
                        void'(word_done(c));
                    end
                    else
                    begin
                        ln_phase = ST_DATE;
                        ln_pos   = '0;
                        date_char(c);
                    end
                end
            end
            ST_SENDER:
                if (word_done(c))
                    ln_phase = ST_SKIP2;
            ST_TTYWORD:
                if (word_done(c))
                    ln_phase = ST_SKIP3;
            ST_DATE:
                date_char(c);
            default:
                ln_phase = ST_REJECT;
        endcase
    endfunction

    function automatic bit predict_verdict(input byte_beat_t b, output verdict_beat_t v);
        take_char(b.data_byte);
        v = '0;
        if (!b.end_of_line)
            return 1'b0;
        v.is_header = ln_phase == ST_ACCEPT;
        v.saw_tty   = ln_tty_seen;
        clear_line_state();
        return 1'b1;
    endfunction

    // mostly short gaps, a few long ones, with quiet stretches of no gaps at all
    function automatic int pick_gap(inout bit quiet, inout int run);
        int r;
        if (run <= 0)
        begin
            quiet = $urandom_range(0, 3) == 0;
            run   = $urandom_range(20, 200);
        end
        run--;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? 8'h20 : 8'h09;
    endfunction

    function automatic logic [7:0] pick_word_char();
        return 8'($urandom_range(35, 126));
    endfunction

    function automatic logic [7:0] class_char(tmpl_class_t cls);
        int r;
        r = $urandom_range(0, 5);
        case (cls)
            CL_A:    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                                 : 8'($urandom_range(97, 122));
            CL_L:    return 8'($urandom_range(97, 122));
            CL_S:    return r == 0 ? 8'h20 : 8'(8 + r);
            CL_O:    return $urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(48, 57));
            CL_D:    return 8'($urandom_range(48, 57));
            CL_C:    return ":";
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_blanks(int lo, int hi);
        int n;
        n = $urandom_range(hi, lo);
        repeat (n) line_buf.push_back(pick_blank());
    endtask

    // sender or tty word, sometimes with quoted spans holding blanks
    task automatic add_word();
        int n;
        int k;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                line_buf.push_back("\"");
                k = $urandom_range(0, 4);
                repeat (k) line_buf.push_back($urandom_range(0, 2) == 0 ? pick_blank()
                                                                       : pick_word_char());
                line_buf.push_back("\"");
            end
            else
                line_buf.push_back(pick_word_char());
        end
    endtask

    task automatic emit_line();
        byte_beat_t b;
        for (int i = 0; i < line_buf.size(); i++)
        begin
            b.data_byte   = line_buf[i];
            b.end_of_line = i == line_buf.size() - 1;
            byte_items.push_back(b);
        end
        line_buf.delete();
        line_count++;
    endtask

    task automatic add_random_line();
        int r;
        int n;
        int idx;
        logic [7:0] d [21];
        r = $urandom_range(0, 99);
        if (r < 62)
        begin
            add_text("From ");
            add_blanks(0, 2);
            add_word();
            add_blanks(1, 3);
            if ($urandom_range(0, 2) == 0)
            begin
                add_text("tty");
                if ($urandom_range(0, 1))
                    add_word();
                add_blanks(1, 2);
            end
            for (int p = 0; p < 21; p++)
                d[p] = class_char(ctime_tmpl[p]);
            // day names that start like a tty word
            case ($urandom_range(0, 5))
                0: d[0] = "t";
                1: begin d[0] = "t"; d[1] = "t"; end
                default: ;
            endcase
            for (int p = 0; p < 21; p++)
                line_buf.push_back(d[p]);
            n = $urandom_range(0, 4);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 5))
                0: line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
                1:
                begin
                    n = $urandom_range(1, line_buf.size() - 1);
                    while (line_buf.size() > n)
                        void'(line_buf.pop_back());
                end
                2:
                begin
                    idx = $urandom_range(0, line_buf.size() - 1);
                    line_buf.insert(idx, 8'h00);
                end
                default: ;
            endcase
        end
        else
        begin
            if (r < 82)
                add_text("From ");
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0:       line_buf.push_back(pick_blank());
                    1:       line_buf.push_back(pick_word_char());
                    default: line_buf.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        emit_line();
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        verdict_beat_t v;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_beat  <= '0;
        end
        else
        begin
            if (byte_valid && byte_ready)
                if (predict_verdict(byte_beat, v))
                    verdicts_due.push_back(v);
            if (!byte_valid || byte_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    byte_valid <= 1'b0;
                end
                else if (byte_items.size() > 0)
                begin
                    byte_beat  <= byte_items.pop_front();
                    byte_valid <= 1'b1;
                    send_gap = pick_gap(send_quiet, send_run);
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_verdicts
        verdict_beat_t want;
        if (!rst_n)
            verdict_ready <= 1'b0;
        else
        begin
            if (verdict_valid && verdict_ready)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch("verdict beat with no line pending");
                else
                begin
                    want = verdicts_due.pop_front();
                    if (verdict_beat.is_header !== want.is_header)
                        report_mismatch($sformatf("is_header got %b want %b",
                                                  verdict_beat.is_header, want.is_header));
                    if (verdict_beat.saw_tty !== want.saw_tty)
                        report_mismatch($sformatf("saw_tty got %b want %b",
                                                  verdict_beat.saw_tty, want.saw_tty));
                end
            end
            if (stall_gap > 0)
            begin
                stall_gap--;
                verdict_ready <= 1'b0;
            end
            else
            begin
                verdict_ready <= 1'b1;
                stall_gap = pick_gap(stall_quiet, stall_run);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && byte_ready) || (verdict_valid && verdict_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        add_text("From a Mon Jan  1 00:00:00 1990");
        emit_line();
        add_text("From \"x y\"\t ttyp0  Sat Dec 31 23:59:59 2000");
        emit_line();
        add_text("From u ttyx\"a b\" Tue Mar  9 01:02:03 x");
        emit_line();
        add_text("From u tue Apr 10 11:22:33 +");
        emit_line();
        // only 20 date characters
        add_text("From u Sun Feb 29 12:34:56 ");
        emit_line();
        add_text("From u");
        line_buf.push_back(8'h00);
        add_text(" Mon Jan  1 00:00:00 1990");
        emit_line();
        add_text("From u Mon Jan  1 00:00:00 1");
        line_buf.push_back(8'h00);
        add_text("zz");
        emit_line();
        add_text("From \"abc def");
        emit_line();
        add_text("from u Mon Jan  1 00:00:00 1990");
        emit_line();
        line_buf.push_back(8'h00);
        emit_line();
        line_buf.push_back(8'hFF);
        emit_line();
        while (byte_items.size() < 1200 || line_count < 40)
            add_random_line();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_items.size() != 0 || byte_valid)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (verdicts_due.size() != 0)
            report_mismatch("verdicts still pending at end");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
